>>> sv/alt_pkg.sv
// shared types and constants for the address lease table with aging
// no dependencies; used by alt_entry_store and address_lease_table_with_aging
package alt_pkg;

  localparam int POOL_ENTRIES = 64;
  localparam int IDX_W        = $clog2(POOL_ENTRIES);
  localparam int CNT_W        = 7;

  typedef enum logic [1:0] {
    ST_FREE   = 2'd0,
    ST_LEASED = 2'd1,
    ST_FIXED  = 2'd2
  } entry_state_t;

  typedef struct packed {
    entry_state_t state;
    logic [31:0]  deadline;
    logic [3:0]   retries;
    logic [31:0]  link;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_ASSIGN = 2'd0,
    CMD_LEARN  = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FLUSH
  } state_t;

  localparam logic [1:0] REG_NETWORK_BASE  = 2'd0;
  localparam logic [1:0] REG_HOST_COUNT    = 2'd1;
  localparam logic [1:0] REG_PROBE_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_PROBE_RETRIES = 2'd3;

  localparam logic [3:0] RES_ASSIGNED  = 4'd0;
  localparam logic [3:0] RES_POOL_FULL = 4'd1;
  localparam logic [3:0] RES_LEARNED   = 4'd2;
  localparam logic [3:0] RES_IGNORED   = 4'd3;
  localparam logic [3:0] RES_HIT       = 4'd4;
  localparam logic [3:0] RES_MISS      = 4'd5;
  localparam logic [3:0] RES_PROBE     = 4'd6;
  localparam logic [3:0] RES_FREED     = 4'd7;
  localparam logic [3:0] RES_TICK_IDLE = 4'd8;

  localparam logic [31:0] TIMEOUT_RESET = 32'd30;
  localparam logic [3:0]  RETRIES_RESET = 4'd10;

endpackage

>>> sv/alt_entry_store.sv
// entry memory of the lease table: one write port, one registered read port
// per-entry valid bits give the reset contents until an entry is written
// depends on alt_pkg
module alt_entry_store (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [alt_pkg::IDX_W-1:0] rd_idx,
  output alt_pkg::entry_t          rd_entry,
  input  logic                     wr_en,
  input  logic [alt_pkg::IDX_W-1:0] wr_idx,
  input  alt_pkg::entry_t          wr_entry
);

  alt_pkg::entry_t                   mem [alt_pkg::POOL_ENTRIES];
  logic [alt_pkg::POOL_ENTRIES-1:0]  vld_r;
  alt_pkg::entry_t                   mem_q;
  logic                              vld_q;
  logic [alt_pkg::IDX_W-1:0]         idx_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
    if (rd_en) begin
      mem_q <= mem[rd_idx];
      vld_q <= vld_r[rd_idx];
      idx_q <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_idx] <= 1'b1;
    end
  end

  // unwritten entry: gateway slot fixed, others free, fields zero
  always_comb begin
    rd_entry = mem_q;
    if (!vld_q) begin
      rd_entry       = '0;
      rd_entry.state = (idx_q == '0) ? alt_pkg::ST_FIXED : alt_pkg::ST_FREE;
    end
  end

endmodule

>>> sv/address_lease_table_with_aging.sv
// top level of the address lease table with aging: command decode, entry scan, results
// depends on alt_pkg and alt_entry_store
// flow: a mapped learn or lookup reads one entry; unmapped ones, and assign or tick when n
//   is 0, load the output register directly; assign and tick scan up to n entries (n =
//   effective host count), one entry read a cycle unless the result side stalls; one
//   transaction at a time, the next taken the cycle after the final result is loaded
// reset: synchronous active low, registers go to their reset values and entry valid
//   bits clear at once, so no clearing pass is needed
module address_lease_table_with_aging (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_ip_address,
  input  logic [15:0] in_link_net,
  input  logic [7:0]  in_link_node,
  input  logic [7:0]  in_link_port,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic [31:0] out_result_address,
  output logic [15:0] out_found_net,
  output logic [7:0]  out_found_node,
  output logic [7:0]  out_found_port,
  output logic        out_last,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IDX_W = alt_pkg::IDX_W;
  localparam int CNT_W = alt_pkg::CNT_W;

  // configuration registers
  logic [31:0]      base_r;
  logic [CNT_W-1:0] host_count_r;
  logic [15:0]      timeout_r;
  logic [3:0]       retries_r;

  // seconds counter
  logic [31:0] sec_r;

  // control
  alt_pkg::state_t state_r, state_nxt;
  alt_pkg::cmd_t   cmd_r;
  logic [31:0]     ip_r;
  logic [31:0]     link_r;
  logic [31:0]     dl_new_r;   // seconds_now + probe_timeout, fixed for the transaction

  // scan issue side
  logic             iss_active_r, iss_active_nxt;
  logic [IDX_W-1:0] iss_idx_r, iss_idx_nxt;
  logic [IDX_W-1:0] iss_last_r, iss_last_nxt;

  // process stage, working on the registered memory read
  logic             p_valid_r, p_valid_nxt;
  logic [IDX_W-1:0] p_idx_r;

  // pending result, held until we know whether it is the final one
  logic        pend_valid_r, pend_valid_nxt;
  logic [3:0]  pend_status_r;
  logic [31:0] pend_addr_r;
  logic [31:0] pend_found_r;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  out_status_r;
  logic [31:0] out_addr_r;
  logic [31:0] out_found_r;
  logic        out_last_r;

  // memory interface
  alt_pkg::entry_t ent;
  alt_pkg::entry_t wr_ent;
  logic            wr_req;
  logic            issue;

  // handshakes and decode
  logic             in_acc;
  logic [CNT_W-1:0] n_eff;
  logic [31:0]      off;
  logic             mapped;
  logic [IDX_W-1:0] map_idx;
  alt_pkg::cmd_t    in_cmd;
  logic             start_scan;

  // process results
  logic        has_res;
  logic [3:0]  res_status;
  logic [31:0] res_addr;
  logic [31:0] res_found;
  logic        stop_scan;
  logic        p_fire;
  logic        out_free;
  logic        push_pend;
  logic        flush_fire;
  logic        scan_done;
  logic [31:0] entry_addr;
  logic [3:0]  dflt_status;
  logic [31:0] dflt_addr;

  assign in_cmd   = alt_pkg::cmd_t'(in_command);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // effective host count saturates at the pool size
  assign n_eff = (host_count_r > CNT_W'(alt_pkg::POOL_ENTRIES)) ?
                 CNT_W'(alt_pkg::POOL_ENTRIES) : host_count_r;

  // address to entry: offset 1..n selects entry offset-1
  assign off     = in_ip_address - base_r;
  assign mapped  = (off != 32'd0) && (off <= 32'(n_eff));
  assign map_idx = IDX_W'(off - 32'd1);

  // commands that touch memory: scans need a nonempty pool, single-entry ones a mapped address
  always_comb begin
    case (in_cmd)
      alt_pkg::CMD_ASSIGN, alt_pkg::CMD_TICK: start_scan = (n_eff != '0);
      default:                                start_scan = mapped;
    endcase
  end

  //------------------------------------------------------------------
  // configuration
  //------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r       <= '0;
      host_count_r <= CNT_W'(alt_pkg::POOL_ENTRIES);
      timeout_r    <= alt_pkg::TIMEOUT_RESET[15:0];
      retries_r    <= alt_pkg::RETRIES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        alt_pkg::REG_NETWORK_BASE:  base_r       <= cfg_data;
        alt_pkg::REG_HOST_COUNT:    host_count_r <= cfg_data[CNT_W-1:0];
        alt_pkg::REG_PROBE_TIMEOUT: timeout_r    <= cfg_data[15:0];
        alt_pkg::REG_PROBE_RETRIES: retries_r    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  //------------------------------------------------------------------
  // entry memory
  //------------------------------------------------------------------
  alt_entry_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (issue),
    .rd_idx   (iss_idx_r),
    .rd_entry (ent),
    .wr_en    (p_fire && wr_req),
    .wr_idx   (p_idx_r),
    .wr_entry (wr_ent)
  );

  //------------------------------------------------------------------
  // process stage: read-modify-write of the entry just read
  //------------------------------------------------------------------
  assign entry_addr = base_r + 32'(p_idx_r) + 32'd1;

  always_comb begin
    has_res    = 1'b0;
    res_status = alt_pkg::RES_TICK_IDLE;
    res_addr   = '0;
    res_found  = '0;
    wr_req     = 1'b0;
    wr_ent     = ent;
    stop_scan  = 1'b0;
    case (cmd_r)
      alt_pkg::CMD_ASSIGN: begin
        // first free entry wins, scan stops there
        if (ent.state == alt_pkg::ST_FREE) begin
          has_res         = 1'b1;
          res_status      = alt_pkg::RES_ASSIGNED;
          res_addr        = entry_addr;
          wr_req          = 1'b1;
          wr_ent.state    = alt_pkg::ST_LEASED;
          wr_ent.deadline = dl_new_r;
          wr_ent.retries  = retries_r;
          wr_ent.link     = link_r;
          stop_scan       = 1'b1;
        end
      end
      alt_pkg::CMD_LEARN: begin
        // fixed entries keep their state but still take the new mapping
        has_res         = 1'b1;
        res_status      = alt_pkg::RES_LEARNED;
        res_addr        = ip_r;
        wr_req          = 1'b1;
        wr_ent.deadline = dl_new_r;
        wr_ent.retries  = retries_r;
        wr_ent.link     = link_r;
        if (ent.state == alt_pkg::ST_FREE) begin
          wr_ent.state = alt_pkg::ST_LEASED;
        end
      end
      alt_pkg::CMD_LOOKUP: begin
        has_res  = 1'b1;
        res_addr = ip_r;
        if (ent.state != alt_pkg::ST_FREE) begin
          res_status = alt_pkg::RES_HIT;
          res_found  = ent.link;
        end else begin
          res_status = alt_pkg::RES_MISS;
        end
      end
      default: begin
        // aging: expired lease is probed while retries remain, then freed
        if (ent.state == alt_pkg::ST_LEASED && ent.deadline < sec_r) begin
          has_res  = 1'b1;
          res_addr = entry_addr;
          wr_req   = 1'b1;
          if (ent.retries != 4'd0) begin
            res_status      = alt_pkg::RES_PROBE;
            wr_ent.retries  = ent.retries - 4'd1;
            wr_ent.deadline = dl_new_r;
          end else begin
            res_status   = alt_pkg::RES_FREED;
            wr_ent.state = alt_pkg::ST_FREE;
          end
        end
      end
    endcase
  end

  // a new result displaces the pending one, which needs the output register
  assign p_fire    = p_valid_r && (!has_res || !pend_valid_r || out_free);
  assign push_pend = p_fire && has_res && pend_valid_r;
  assign issue     = iss_active_r && (!p_valid_r || p_fire) && !(p_fire && stop_scan);
  assign scan_done = !iss_active_r && !p_valid_r;

  // result when nothing was produced by the scan
  always_comb begin
    case (cmd_r)
      alt_pkg::CMD_ASSIGN: begin
        dflt_status = alt_pkg::RES_POOL_FULL;
        dflt_addr   = '0;
      end
      alt_pkg::CMD_LEARN: begin
        dflt_status = alt_pkg::RES_IGNORED;
        dflt_addr   = ip_r;
      end
      alt_pkg::CMD_LOOKUP: begin
        dflt_status = alt_pkg::RES_MISS;
        dflt_addr   = ip_r;
      end
      default: begin
        dflt_status = alt_pkg::RES_TICK_IDLE;
        dflt_addr   = '0;
      end
    endcase
  end

  //------------------------------------------------------------------
  // control state machine
  //------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      alt_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = start_scan ? alt_pkg::S_RUN : alt_pkg::S_FLUSH;
        end
      end
      alt_pkg::S_RUN: begin
        if (scan_done) begin
          state_nxt = alt_pkg::S_FLUSH;
        end
      end
      alt_pkg::S_FLUSH: begin
        if (out_free) begin
          state_nxt = alt_pkg::S_IDLE;
        end
      end
      default: state_nxt = alt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    flush_fire = 1'b0;
    unique case (state_r)
      alt_pkg::S_IDLE:  in_stall   = 1'b0;
      alt_pkg::S_RUN:   in_stall   = 1'b1;
      alt_pkg::S_FLUSH: flush_fire = out_free;
      default:          in_stall   = 1'b1;
    endcase
  end

  //------------------------------------------------------------------
  // scan counters and pipeline valid
  //------------------------------------------------------------------
  always_comb begin
    iss_active_nxt = iss_active_r;
    iss_idx_nxt    = iss_idx_r;
    iss_last_nxt   = iss_last_r;
    if (in_acc) begin
      iss_active_nxt = start_scan;
      if (in_cmd == alt_pkg::CMD_LEARN || in_cmd == alt_pkg::CMD_LOOKUP) begin
        iss_idx_nxt  = map_idx;
        iss_last_nxt = map_idx;
      end else begin
        iss_idx_nxt  = '0;
        iss_last_nxt = IDX_W'(n_eff - CNT_W'(1));
      end
    end else if (p_fire && stop_scan) begin
      iss_active_nxt = 1'b0;
    end else if (issue) begin
      iss_idx_nxt = iss_idx_r + IDX_W'(1);
      if (iss_idx_r == iss_last_r) begin
        iss_active_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    p_valid_nxt = p_valid_r;
    if (p_fire && stop_scan) begin
      p_valid_nxt = 1'b0;
    end else if (issue) begin
      p_valid_nxt = 1'b1;
    end else if (p_fire) begin
      p_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    if (p_fire && has_res) begin
      pend_valid_nxt = 1'b1;
    end else if (flush_fire) begin
      pend_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (push_pend || flush_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  //------------------------------------------------------------------
  // registers
  //------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= alt_pkg::S_IDLE;
      iss_active_r <= 1'b0;
      p_valid_r    <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      sec_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      iss_active_r <= iss_active_nxt;
      p_valid_r    <= p_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (in_acc && in_cmd == alt_pkg::CMD_TICK) begin
        sec_r <= sec_r + 32'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    iss_idx_r  <= iss_idx_nxt;
    iss_last_r <= iss_last_nxt;
    if (issue) begin
      p_idx_r <= iss_idx_r;
    end
    if (in_acc) begin
      cmd_r  <= in_cmd;
      ip_r   <= in_ip_address;
      link_r <= {in_link_net, in_link_node, in_link_port};
      // a tick ages against the already advanced seconds count
      if (in_cmd == alt_pkg::CMD_TICK) begin
        dl_new_r <= sec_r + 32'(timeout_r) + 32'd1;
      end else begin
        dl_new_r <= sec_r + 32'(timeout_r);
      end
    end
    if (p_fire && has_res) begin
      pend_status_r <= res_status;
      pend_addr_r   <= res_addr;
      pend_found_r  <= res_found;
    end
    if (push_pend) begin
      out_status_r <= pend_status_r;
      out_addr_r   <= pend_addr_r;
      out_found_r  <= pend_found_r;
      out_last_r   <= 1'b0;
    end else if (flush_fire) begin
      out_last_r <= 1'b1;
      if (pend_valid_r) begin
        out_status_r <= pend_status_r;
        out_addr_r   <= pend_addr_r;
        out_found_r  <= pend_found_r;
      end else begin
        out_status_r <= dflt_status;
        out_addr_r   <= dflt_addr;
        out_found_r  <= '0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_address = out_addr_r;
  assign out_found_net      = out_found_r[31:16];
  assign out_found_node     = out_found_r[15:8];
  assign out_found_port     = out_found_r[7:0];
  assign out_last           = out_last_r;

endmodule

>>> tb/sv/address_lease_table_with_aging_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the address lease table with aging
// depends on alt_pkg and the address_lease_table_with_aging rtl; a small scoreboard class
// predicts every result, plain tasks drive the command and configuration channels
module address_lease_table_with_aging_tb;
  import alt_pkg::*;

  localparam int RUN_LIMIT   = 800000;  // cycles before the run is declared hung
  localparam int HOLD_CYCLES = 200;     // long receiver hold-off
  localparam int SETTLE      = 100;     // a full scan of 64 entries plus margin

  // one expected or observed result transaction
  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] addr;
    logic [15:0] net;
    logic [7:0]  node;
    logic [7:0]  port;
    logic        last;
  } lease_result_t;

  // shadow of the lease pool and its registers, plus the queue of results still owed
  class lease_scoreboard;
    entry_state_t  slot_state    [POOL_ENTRIES];
    logic [31:0]   slot_deadline [POOL_ENTRIES];
    logic [3:0]    slot_retries  [POOL_ENTRIES];
    logic [31:0]   slot_link     [POOL_ENTRIES];
    logic [31:0]   seconds;
    logic [31:0]   net_base;
    logic [6:0]    host_count;
    logic [15:0]   probe_timeout;
    logic [3:0]    probe_retries;
    lease_result_t owed_q[$];
    int            errors;

    function new();
      for (int i = 0; i < POOL_ENTRIES; i++) begin
        slot_state[i]    = ST_FREE;
        slot_deadline[i] = '0;
        slot_retries[i]  = '0;
        slot_link[i]     = '0;
      end
      slot_state[0] = ST_FIXED;  // gateway
      seconds       = '0;
      net_base      = '0;
      host_count    = 7'd64;
      probe_timeout = 16'(TIMEOUT_RESET);
      probe_retries = RETRIES_RESET;
      errors        = 0;
    endfunction

    function int usable();
      return (int'(host_count) > POOL_ENTRIES) ? POOL_ENTRIES : int'(host_count);
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_NETWORK_BASE:  net_base      = data;
        REG_HOST_COUNT:    host_count    = data[6:0];
        REG_PROBE_TIMEOUT: probe_timeout = data[15:0];
        REG_PROBE_RETRIES: probe_retries = data[3:0];
        default: ;
      endcase
    endfunction

    function void owe(logic [3:0] status, logic [31:0] addr, logic [31:0] link);
      lease_result_t r;
      r.status = status;
      r.addr   = addr;
      r.net    = link[31:16];
      r.node   = link[15:8];
      r.port   = link[7:0];
      r.last   = 1'b0;
      owed_q.push_back(r);
    endfunction

    function void refresh(int slot, logic [31:0] link);
      slot_link[slot]     = link;
      slot_deadline[slot] = seconds + {16'd0, probe_timeout};
      slot_retries[slot]  = probe_retries;
    endfunction

    // an accepted command: update the pool and queue the results it owes
    function void note_command(cmd_t op, logic [31:0] ip, logic [31:0] link);
      int n;
      int slot;
      int pick;
      int prior_count;
      logic [31:0] off;
      n           = usable();
      prior_count = owed_q.size();
      off         = ip - net_base;
      slot        = (off >= 1 && off <= 32'(n)) ? int'(off) - 1 : -1;
      pick        = -1;
      case (op)
        CMD_ASSIGN: begin
          for (int i = n - 1; i >= 0; i--)
            if (slot_state[i] == ST_FREE) pick = i;
          if (pick >= 0) begin
            slot_state[pick] = ST_LEASED;
            refresh(pick, link);
            owe(RES_ASSIGNED, net_base + 32'(pick) + 32'd1, '0);
          end else begin
            owe(RES_POOL_FULL, '0, '0);
          end
        end
        CMD_LEARN: begin
          if (slot >= 0) begin
            refresh(slot, link);
            if (slot_state[slot] == ST_FREE) slot_state[slot] = ST_LEASED;
            owe(RES_LEARNED, ip, '0);
          end else begin
            owe(RES_IGNORED, ip, '0);
          end
        end
        CMD_LOOKUP: begin
          if (slot >= 0 && slot_state[slot] != ST_FREE) owe(RES_HIT, ip, slot_link[slot]);
          else owe(RES_MISS, ip, '0);
        end
        default: begin
          seconds = seconds + 32'd1;
          for (int i = 0; i < n; i++) begin
            if (slot_state[i] == ST_LEASED && slot_deadline[i] < seconds) begin
              if (slot_retries[i] != 0) begin
                slot_retries[i]  = slot_retries[i] - 4'd1;
                slot_deadline[i] = seconds + {16'd0, probe_timeout};
                owe(RES_PROBE, net_base + 32'(i) + 32'd1, '0);
              end else begin
                slot_state[i] = ST_FREE;
                owe(RES_FREED, net_base + 32'(i) + 32'd1, '0);
              end
            end
          end
          if (owed_q.size() == prior_count) owe(RES_TICK_IDLE, '0, '0);
        end
      endcase
      owed_q[owed_q.size() - 1].last = 1'b1;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // an accepted result: compare against the oldest one owed
    function void check_result(lease_result_t got);
      lease_result_t want;
      if (owed_q.size() == 0) begin
        $error("result with nothing owed: status %0d address 0x%0h", got.status, got.addr);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("result_address", want.addr, got.addr);
      compare_field("found_net", 32'(want.net), 32'(got.net));
      compare_field("found_node", 32'(want.node), 32'(got.node));
      compare_field("found_port", 32'(want.port), 32'(got.port));
      compare_field("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = '0;
  logic [31:0] in_ip_address = '0;
  logic [15:0] in_link_net = '0;
  logic [7:0]  in_link_node = '0;
  logic [7:0]  in_link_port = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_status;
  logic [31:0] out_result_address;
  logic [15:0] out_found_net;
  logic [7:0]  out_found_node;
  logic [7:0]  out_found_port;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  lease_scoreboard sb;
  int send_idle_pct = 0;  // chance the sender idles before a transaction
  int stall_pct = 0;      // chance the receiver stalls in a cycle
  int hold_requests = 0;  // bumped by the stimulus to ask for a long hold-off
  int hold_served = 0;
  int hold_left = 0;
  int cycle_count = 0;

  address_lease_table_with_aging DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_ip_address      (in_ip_address),
    .in_link_net        (in_link_net),
    .in_link_node       (in_link_node),
    .in_link_port       (in_link_port),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_result_address (out_result_address),
    .out_found_net      (out_found_net),
    .out_found_node     (out_found_node),
    .out_found_port     (out_found_port),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit: a hung handshake ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor: everything is sampled at the edge, so values are the ones the dut saw
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_command(cmd_t'(in_command), in_ip_address,
                        {in_link_net, in_link_node, in_link_port});
      if (out_valid && !out_stall)
        sb.check_result({out_status, out_result_address, out_found_net,
                         out_found_node, out_found_port, out_last});
    end
  end

  // offer one command transaction, with an optional random gap before it,
  // and return at the edge where it is taken
  task automatic send_command(cmd_t op, logic [31:0] ip, logic [31:0] link);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= op;
    in_ip_address <= ip;
    in_link_net   <= link[31:16];
    in_link_node  <= link[15:8];
    in_link_port  <= link[7:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop offering and wait for every owed result
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes need no re-raise
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // registers only change with the pool idle
  task automatic configure(logic [31:0] base, int count, int timeout, int retries);
    wait_drain();
    write_reg(REG_NETWORK_BASE, base);
    write_reg(REG_HOST_COUNT, 32'(count));
    write_reg(REG_PROBE_TIMEOUT, 32'(timeout));
    write_reg(REG_PROBE_RETRIES, 32'(retries));
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    stall_pct    <= recv_pct;
  endtask

  // hand-picked corners: gateway, window edges, last entry, aging, empty pool
  task automatic run_directed();
    // reset register values, base 0, 64 hosts
    send_command(CMD_LOOKUP, 32'd1, '0);            // fixed gateway hits
    send_command(CMD_LOOKUP, 32'd0, '0);            // network address itself
    send_command(CMD_LOOKUP, 32'd65, '0);           // one past the pool
    send_command(CMD_LEARN, 32'd64, 32'hFFFF_FFFF); // last entry is reachable
    send_command(CMD_LOOKUP, 32'd64, '0);
    send_command(CMD_LEARN, 32'd1, 32'h1234_5678);  // gateway stays fixed
    send_command(CMD_LOOKUP, 32'd1, '0);
    send_command(CMD_LEARN, 32'd65, 32'h0000_0001);
    send_command(CMD_LEARN, 32'hFFFF_FFFF, '0);
    send_command(CMD_ASSIGN, '0, 32'hA5A5_5A5A);
    send_command(CMD_TICK, '0, '0);
    // oversized host count saturates; short timeout walks a lease to probe then free
    configure(32'd0, 127, 1, 1);
    send_command(CMD_ASSIGN, '0, 32'h0102_0304);
    send_command(CMD_TICK, '0, '0);
    send_command(CMD_TICK, '0, '0);
    send_command(CMD_TICK, '0, '0);
    send_command(CMD_TICK, '0, '0);
    // no usable entry at all
    configure(32'hFFFF_FFFF, 0, 1, 1);
    send_command(CMD_ASSIGN, '0, 32'h0000_0001);
    send_command(CMD_LEARN, 32'd0, 32'h0000_0001);
    send_command(CMD_LOOKUP, 32'd0, '0);
    send_command(CMD_TICK, '0, '0);
    // single entry, address wraps to zero, gateway only
    configure(32'hFFFF_FFFF, 1, 1, 1);
    send_command(CMD_LOOKUP, 32'd0, '0);
    send_command(CMD_ASSIGN, '0, 32'h0000_0002);
    send_command(CMD_LEARN, 32'd0, 32'hFEDC_BA98);
  endtask

  // random commands, mostly inside the address window (edges included)
  task automatic run_random(int items, bit pressure);
    int roll;
    int saved_idle;
    cmd_t op;
    logic [31:0] ip;
    saved_idle = send_idle_pct;
    for (int k = 0; k < items; k++) begin
      if (pressure && k == items / 4) begin
        // receiver goes quiet while the sender keeps pushing
        hold_requests <= hold_requests + 1;
        send_idle_pct = 0;
      end
      if (pressure && k == items / 4 + 12) send_idle_pct = saved_idle;
      if (pressure && k == items / 2) wait_drain();  // sender pause until empty
      roll = $urandom_range(99);
      if (roll < 22) op = CMD_ASSIGN;
      else if (roll < 45) op = CMD_LEARN;
      else if (roll < 72) op = CMD_LOOKUP;
      else op = CMD_TICK;
      if ($urandom_range(99) < 75) ip = sb.net_base + 32'($urandom_range(sb.usable() + 1));
      else ip = $urandom;
      send_command(op, ip, $urandom);
    end
  endtask

  task automatic run_phase(logic [31:0] base, int count, int timeout, int retries,
                           int send_pct, int recv_pct, int items, bit pressure);
    configure(base, count, timeout, retries);
    set_idling(send_pct, recv_pct);
    run_random(items, pressure);
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // base, hosts, timeout, retries, sender idle %, receiver stall %, transactions
    run_phase($urandom, 64, 2, 1, 0, 0, 80, 1'b0);
    run_phase(32'hFFFF_FFFC, 5, 1, 0, 48, 0, 60, 1'b0);
    run_phase($urandom, 127, 3, 2, 0, 48, 80, 1'b1);
    run_phase(32'd0, 64, 65535, 15, 25, 25, 50, 1'b0);
    run_phase($urandom, 2, 1, 3, 25, 25, 60, 1'b0);
    run_phase($urandom, $urandom_range(64, 1), $urandom_range(4, 1), $urandom_range(15),
              48, 0, 80, 1'b0);
    run_phase(32'hFFFF_FFFF, 64, 1, 0, 0, 0, 60, 1'b0);

    wait_drain();
    // catch any stray result after the last expected one
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> address_lease_table_with_aging.f
sv/alt_pkg.sv
sv/alt_entry_store.sv
sv/address_lease_table_with_aging.sv
tb/sv/address_lease_table_with_aging_tb.sv
